// File: hdl/fcc_pkg.sv
// ============================================================================
// fcc_pkg: shared types, constants and functions of the frontier classifier
// Cell codes, window geometry and the classification function.
// ============================================================================
package fcc_pkg;

    // Line buffer geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W     = (WIDTH_W > 12) ? WIDTH_W : 12;

    // Output field widths
    localparam int ROW_W   = 16;
    localparam int OCOL_W  = 11;
    localparam int CLASS_W = 2;

    // 2-bit cell codes
    localparam logic [1:0] CODE_NEUTRAL  = 2'd0;
    localparam logic [1:0] CODE_FREE     = 2'd1;
    localparam logic [1:0] CODE_UNKNOWN  = 2'd2;
    localparam logic [1:0] CODE_OCCUPIED = 2'd3;

    // Result classes
    localparam logic [CLASS_W-1:0] CLS_NONE     = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_OBSTACLE = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_FRONTIER = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // One line buffer word: codes of the four buffered rows, oldest at [0]
    typedef logic [3:0][1:0] t_lb_word;
    // 5x5 window, [row][col], row 0 oldest, col 4 newest
    typedef logic [4:0][4:0][1:0] t_win;

    // Control from the top level to the line buffer
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        logic [1:0]       code;
    } t_lb_ctrl;

    function automatic logic [1:0] encode_cell(input logic [7:0] v);
        logic [1:0] c;
        unique case (v)
            8'h00:   c = CODE_FREE;
            8'hFF:   c = CODE_UNKNOWN;
            8'd100:  c = CODE_OCCUPIED;
            default: c = CODE_NEUTRAL;
        endcase
        return c;
    endfunction

    function automatic logic is_free(input t_win w, input int r, input int c);
        return w[r][c] == CODE_FREE;
    endfunction

    // Class of the window centre
    function automatic logic [CLASS_W-1:0] classify(input t_win w);
        logic front;
        front = (is_free(w, 3, 2) && (is_free(w, 4, 2) || is_free(w, 3, 3) || is_free(w, 3, 1)))
             || (is_free(w, 2, 3) && (is_free(w, 2, 4) || is_free(w, 3, 3) || is_free(w, 1, 3)))
             || (is_free(w, 1, 2) && (is_free(w, 0, 2) || is_free(w, 1, 3) || is_free(w, 1, 1)))
             || (is_free(w, 2, 1) && (is_free(w, 2, 0) || is_free(w, 3, 1) || is_free(w, 1, 1)));
        if (w[2][2] == CODE_OCCUPIED) begin
            return CLS_OBSTACLE;
        end else if (w[2][2] == CODE_UNKNOWN && front) begin
            return CLS_FRONTIER;
        end
        return CLS_NONE;
    endfunction

endpackage

// File: hdl/fcc_linebuf.sv
// ============================================================================
// fcc_linebuf: line buffer memory and 5x5 window
// One word per column holds four buffered rows; read, shift, write back.
// ============================================================================
module fcc_linebuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fcc_pkg::t_lb_ctrl     i_ctrl,
    output fcc_pkg::t_win         o_win_next
);

    fcc_pkg::t_lb_word mem [fcc_pkg::MAX_WIDTH];
    fcc_pkg::t_lb_word r_rd_data;
    fcc_pkg::t_lb_word r_fwd_data;
    logic              r_fwd;
    fcc_pkg::t_win     r_win;
    fcc_pkg::t_lb_word rd_word;
    fcc_pkg::t_lb_word wr_word;
    logic [4:0][1:0]   column;

    // Read port, registered; write port shares the clock
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= mem[i_ctrl.rd_addr];
        end
        if (i_ctrl.wr_en) begin
            mem[i_ctrl.wr_addr] <= wr_word;
        end
    end

    // Same column written back while being read: take the new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_ctrl.rd_en) begin
            r_fwd <= i_ctrl.wr_en && (i_ctrl.wr_addr == i_ctrl.rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_fwd_data <= wr_word;
        end
    end

    assign rd_word = r_fwd ? r_fwd_data : r_rd_data;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            column[k] = rd_word[k];
        end
        column[4] = i_ctrl.code;
        for (int k = 0; k < 4; k++) begin
            wr_word[k] = column[k+1];
        end
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 4; c++) begin
                o_win_next[r][c] = r_win[r][c+1];
            end
            o_win_next[r][4] = column[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_ctrl.wr_en) begin
            r_win <= o_win_next;
        end
    end

    // Forward flag only changes on a read
    a_fwd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.rd_en |=> r_fwd == $past(r_fwd))
        else $error("forward flag changed without a read");

    // A forward is taken only when the write hit the read column
    a_fwd_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.rd_en && i_ctrl.wr_en && i_ctrl.wr_addr != i_ctrl.rd_addr |=> !r_fwd)
        else $error("forward without address match");

    // Window frozen while no column is consumed
    a_win_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.wr_en |=> $stable(r_win))
        else $error("window shifted without a column");

endmodule

// File: hdl/frontier_cell_classifier.sv
// ============================================================================
// frontier_cell_classifier: occupancy grid frontier / obstacle classifier
// Raster stream of cells in, one class per interior cell out.
// ============================================================================
//
//  channel   | dir | handshake                 | payload
//  ----------+-----+---------------------------+-------------------------------
//  input     | in  | i_s_tvalid / o_s_tready   | tdata cell_value, tuser first_cell
//  output    | out | o_m_tvalid / i_m_tready   | tdata row/col/class, tlast map_last
//  config    | in  | psel penable pwrite pready| paddr 0 grid_width, 4 grid_height
//
//  One beat per cycle sustained while the output is not stalled. An accepted
//  beat reads its column word from the line buffer memory (single read port,
//  registered read), then shifts the window, writes the column back and loads
//  the output register. Output stall holds the middle stage and input ready
//  drops; one beat may enter while a result waits. Synchronous active-low
//  reset clears counters, window and valid flags; the line buffer memory is
//  not cleared and needs no sweep.
//
module frontier_cell_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] cell_value (signed)
    input  logic        i_s_tuser,   // [0] first_cell
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] cell_row, [26:16] cell_col,
                                     // [28:27] cell_class, [31:29] zero
    output logic        o_m_tlast,   // map_last
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W   = fcc_pkg::COL_W;
    localparam int WIDTH_W = fcc_pkg::WIDTH_W;
    localparam int CMP_W   = fcc_pkg::CMP_W;
    localparam int ROW_W   = fcc_pkg::ROW_W;

    // ---------------- config registers ----------------
    logic [11:0] r_grid_width;
    logic [15:0] r_grid_height;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 12'd384;
            r_grid_height <= 16'd384;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                fcc_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[11:0];
                fcc_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            fcc_pkg::REG_GRID_WIDTH:  prdata = {20'd0, r_grid_width};
            fcc_pkg::REG_GRID_HEIGHT: prdata = {16'd0, r_grid_height};
            default:                  prdata = '0;
        endcase
    end

    // Geometry in use: width clamped to 5..MAX_WIDTH, height to at least 5
    logic [CMP_W-1:0]   gw_ext;
    logic [WIDTH_W-1:0] width_use;
    logic [ROW_W-1:0]   height_use;

    always_comb begin
        gw_ext = CMP_W'(r_grid_width);
        if (gw_ext < CMP_W'(5)) begin
            width_use = WIDTH_W'(5);
        end else if (gw_ext > CMP_W'(fcc_pkg::MAX_WIDTH)) begin
            width_use = WIDTH_W'(fcc_pkg::MAX_WIDTH);
        end else begin
            width_use = WIDTH_W'(gw_ext);
        end
        height_use = (r_grid_height < 16'd5) ? 16'd5 : r_grid_height;
    end

    // ---------------- raster counters (accept stage) ----------------
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] eff_row;
    logic [COL_W-1:0] eff_col;
    logic             s_acc;
    logic             active;
    logic             col_wrap;
    logic             emit;
    logic             last;

    assign s_acc   = i_s_tvalid && o_s_tready;
    assign eff_row = i_s_tuser ? '0 : r_row;
    assign eff_col = i_s_tuser ? '0 : r_col;
    assign active  = eff_row < height_use;  // past the map: beat dropped

    assign col_wrap = (WIDTH_W'(eff_col) + WIDTH_W'(1)) >= width_use;
    assign emit     = (eff_row >= ROW_W'(4)) && (eff_col >= COL_W'(4))
                   && (WIDTH_W'(eff_col) < width_use);
    assign last     = ((17'(eff_row) + 17'd1) == 17'(height_use))
                   && ((WIDTH_W'(eff_col) + WIDTH_W'(1)) == width_use);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (s_acc && active) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= eff_row + ROW_W'(1);
            end else begin
                r_col <= eff_col + COL_W'(1);
                r_row <= eff_row;
            end
        end
    end

    // ---------------- middle stage: memory read in flight ----------------
    logic                      r_s1_valid;
    logic                      r_s1_emit;
    logic                      r_s1_last;
    logic [ROW_W-1:0]          r_s1_row;
    logic [COL_W-1:0]          r_s1_col;
    logic [1:0]                r_s1_code;
    logic                      r_out_valid;
    logic                      s1_adv;
    logic                      s1_fire;
    fcc_pkg::t_lb_ctrl         lb_ctrl;
    fcc_pkg::t_win             win_next;

    assign s1_adv     = !r_out_valid || i_m_tready;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign o_s_tready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= s_acc && active;
            r_s1_emit  <= s_acc && active && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_row  <= eff_row;
            r_s1_col  <= eff_col;
            r_s1_last <= last;
            r_s1_code <= fcc_pkg::encode_cell(i_s_tdata);
        end
    end

    always_comb begin
        lb_ctrl.rd_en   = s_acc && active;
        lb_ctrl.rd_addr = eff_col;
        lb_ctrl.wr_en   = s1_fire;
        lb_ctrl.wr_addr = r_s1_col;
        lb_ctrl.code    = r_s1_code;
    end

    fcc_linebuf u_linebuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (lb_ctrl),
        .o_win_next (win_next)
    );

    // ---------------- output register ----------------
    logic [ROW_W-1:0]              r_out_row;
    logic [fcc_pkg::OCOL_W-1:0]    r_out_col;
    logic [fcc_pkg::CLASS_W-1:0]   r_out_cls;
    logic                          r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // centre cell sits two rows up and two columns left
    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_emit) begin
            r_out_row  <= r_s1_row - ROW_W'(2);
            r_out_col  <= fcc_pkg::OCOL_W'(r_s1_col - COL_W'(2));
            r_out_cls  <= fcc_pkg::classify(win_next);
            r_out_last <= r_s1_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_out_cls, r_out_col, r_out_row};
    assign o_m_tlast  = r_out_last;

    // ---------------- assertions ----------------
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |-> !o_s_tready)
        else $error("input taken while middle stage stalled");

    a_class_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_cls != 2'd3)
        else $error("illegal class code");

    a_first_cell_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && i_s_tuser |=> r_s1_valid && r_s1_col == '0 && r_s1_row == '0)
        else $error("first cell not placed at origin");

    a_emit_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_emit |-> r_s1_valid)
        else $error("result flag without a beat in flight");

endmodule

// File: dv/frontier_cell_classifier_tb.sv
// ============================================================================
// frontier_cell_classifier_tb: self-checking bench for the frontier classifier
// Streams occupancy grids in raster order through the slave port, predicts
// the obstacle / frontier class of every interior cell with a local window
// model and checks each master beat against it. Geometry is reprogrammed
// over APB between maps and once mid-map, under three sender/receiver idling profiles.
// ============================================================================
module frontier_cell_classifier_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Occupancy values with a meaning; anything else is neutral
    localparam logic [7:0] CELL_FREE_VAL     = 8'h00;
    localparam logic [7:0] CELL_UNKNOWN_VAL  = 8'hFF;
    localparam logic [7:0] CELL_OCCUPIED_VAL = 8'd100;

    localparam int DRAIN_CYCLES      = 8;
    localparam int CELLS_PER_PROFILE = 340;        // random cells per idling profile
    localparam int MAX_REPORTS       = 10;
    localparam longint TIMEOUT_NS    = 2_000_000;

    // Hand-made 7x5 map. Centres of row 2: col 2 occupied, col 3 neutral,
    // col 4 unknown with two free cells to its right (reachable frontier).
    // Field extremes -128 / 127 and near-miss values 99, 101, -2 sit around.
    localparam byte HAND_MAP [35] = '{
        -128,  127,    0,    0,    1,   -1,   99,
           0,  100,    0,   -1,    0,  101,    0,
          -1,    0,  100,  127,   -1,    0,    0,
           0,   -1,    0,    0,   -2,  100,   -1,
         100,    0,    0,   -1,    0,   64, -128
    };

    typedef struct {
        logic [7:0] value;
        logic       first;
    } t_cell_beat;

    typedef struct {
        logic [fcc_pkg::ROW_W-1:0]   row;
        logic [fcc_pkg::OCOL_W-1:0]  col;
        logic [fcc_pkg::CLASS_W-1:0] cls;
        logic                        last;
    } t_cell_result;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;       // [7:0] cell_value
    logic        s_tuser  = 1'b0;     // [0] first_cell
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;             // [15:0] row, [26:16] col, [28:27] class
    logic        m_tlast;             // map_last
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    frontier_cell_classifier u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_cell_beat   cells_to_send[$];       // beats not yet accepted; [0] is on the bus
    t_cell_result expected_classes[$];    // predicted results, oldest first

    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    bit  send_done      = 1'b0;           // input beat taken at the last rising edge
    int  mismatch_count = 0;
    int  random_cells   = 0;

    // Window model: own copy of geometry, line buffers, window and counters
    logic [11:0]  width_reg;
    logic [15:0]  height_reg;
    logic [1:0]   hist_rows [4][fcc_pkg::MAX_WIDTH];   // [0] oldest buffered row
    logic [1:0]   nbhd [5][5];                // [row][col], row 0 oldest, col 4 newest
    int unsigned  row_idx;
    int unsigned  col_idx;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction: one accepted cell beat, zero or one class result
    // ------------------------------------------------------------------------
    task automatic predict_cell(input logic [7:0] value, input logic first);
        int unsigned  wid;
        int unsigned  hgt;
        int unsigned  col;
        int           dr;
        int           dc;
        logic [1:0]   code;
        logic [1:0]   column [5];
        logic         frontier;
        t_cell_result res;

        // Geometry in use: width saturates to 5..MAX_WIDTH, height to >= 5
        wid = (width_reg < 5) ? 5 :
              (width_reg > fcc_pkg::MAX_WIDTH) ? fcc_pkg::MAX_WIDTH : width_reg;
        hgt = (height_reg < 5) ? 5 : height_reg;

        case (value)
            CELL_FREE_VAL:     code = fcc_pkg::CODE_FREE;
            CELL_UNKNOWN_VAL:  code = fcc_pkg::CODE_UNKNOWN;
            CELL_OCCUPIED_VAL: code = fcc_pkg::CODE_OCCUPIED;
            default:           code = fcc_pkg::CODE_NEUTRAL;
        endcase

        if (first) begin
            row_idx = 0;
            col_idx = 0;
        end
        // past the last row: dropped until the next map start
        if (row_idx >= hgt) return;

        // column of the line buffers moves up by one row, new code at the bottom
        col = col_idx % fcc_pkg::MAX_WIDTH;
        for (int k = 0; k < 4; k++) column[k] = hist_rows[k][col];
        column[4] = code;
        for (int k = 0; k < 4; k++) hist_rows[k][col] = column[k + 1];

        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 4; c++) nbhd[r][c] = nbhd[r][c + 1];
            nbhd[r][4] = column[r];
        end

        if (row_idx >= 4 && col_idx >= 4 && col_idx < wid) begin
            // frontier: a free orthogonal neighbour with a free cell beyond it
            // or at one of its two sides
            frontier = 1'b0;
            for (int d = 0; d < 4; d++) begin
                dr = (d == 0) ? 1 : (d == 2) ? -1 : 0;
                dc = (d == 1) ? 1 : (d == 3) ? -1 : 0;
                if (nbhd[2 + dr][2 + dc] == fcc_pkg::CODE_FREE &&
                    (nbhd[2 + 2 * dr][2 + 2 * dc] == fcc_pkg::CODE_FREE ||
                     nbhd[2 + dr + dc][2 + dc + dr] == fcc_pkg::CODE_FREE ||
                     nbhd[2 + dr - dc][2 + dc - dr] == fcc_pkg::CODE_FREE))
                    frontier = 1'b1;
            end
            res.row = fcc_pkg::ROW_W'(row_idx - 2);
            res.col = fcc_pkg::OCOL_W'(col_idx - 2);
            if (nbhd[2][2] == fcc_pkg::CODE_OCCUPIED) begin
                res.cls = fcc_pkg::CLS_OBSTACLE;
            end else if (nbhd[2][2] == fcc_pkg::CODE_UNKNOWN && frontier) begin
                res.cls = fcc_pkg::CLS_FRONTIER;
            end else begin
                res.cls = fcc_pkg::CLS_NONE;
            end
            res.last = (row_idx + 1 == hgt) && (col_idx + 1 == wid);
            expected_classes.insert(expected_classes.size(), res);
        end

        // a column at or past a shrunken width also wraps here
        if (col_idx + 1 >= wid) begin
            col_idx = 0;
            row_idx++;
        end else begin
            col_idx++;
        end
    endtask

    task automatic log_mismatch(input string note);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $realtime, note);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample both streams at the rising edge. Output beats are
    // checked first; an input beat taken at the same edge cannot own them.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_classes.size() == 0) begin
                    log_mismatch($sformatf("unexpected beat: row %0d col %0d class %0d last %0d",
                                           m_tdata[15:0], m_tdata[26:16], m_tdata[28:27],
                                           m_tlast));
                end else begin
                    want = expected_classes.pop_front();
                    if (m_tdata[15:0] !== want.row || m_tdata[26:16] !== want.col ||
                        m_tdata[28:27] !== want.cls || m_tlast !== want.last ||
                        m_tdata[31:29] !== 3'b000)
                        log_mismatch($sformatf({"class mismatch: exp row %0d col %0d class %0d",
                                                " last %0d, got row %0d col %0d class %0d",
                                                " last %0d pad %b"},
                                               want.row, want.col, want.cls, want.last,
                                               m_tdata[15:0], m_tdata[26:16], m_tdata[28:27],
                                               m_tlast, m_tdata[31:29]));
                end
            end
            send_done = s_tvalid && s_tready;
            if (send_done) begin
                predict_cell(s_tdata, s_tuser);
                void'(cells_to_send.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge. A beat on the bus stays put
    // until taken; random gaps only start between beats.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || send_done) begin
                if (cells_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= cells_to_send[0].value;
                    s_tuser  <= cells_to_send[0].first;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_cell(input logic [7:0] value, input logic first);
        t_cell_beat b;
        b.value = value;
        b.first = first;
        cells_to_send.insert(cells_to_send.size(), b);
    endtask

    // Mostly meaningful codes so frontiers show up; the rest any 8-bit value
    function automatic logic [7:0] pick_cell_value();
        int unsigned roll;
        roll = $urandom_range(0, 15);
        if (roll < 5)  return CELL_FREE_VAL;
        if (roll < 10) return CELL_UNKNOWN_VAL;
        if (roll < 13) return CELL_OCCUPIED_VAL;
        return 8'($urandom());
    endfunction

    // Stream drained, plus a DRAIN_CYCLES wait for a cell that yields no result
    task automatic wait_idle();
        while (cells_to_send.size() != 0 || s_tvalid || expected_classes.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Setup cycle, access cycle; the register takes the value at the edge
    // that ends the access cycle. The model copy follows once it is done.
    task automatic apb_write(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            fcc_pkg::REG_GRID_WIDTH:  width_reg  = value[11:0];
            fcc_pkg::REG_GRID_HEIGHT: height_reg = value[15:0];
        endcase
    endtask

    // Both registers, junk in the unused upper bits
    task automatic set_geometry(input int unsigned wval, input int unsigned hval);
        wait_idle();
        apb_write(fcc_pkg::REG_GRID_WIDTH, ($urandom() & 32'hFFFF_F000) | (wval & 32'hFFF));
        apb_write(fcc_pkg::REG_GRID_HEIGHT, ($urandom() & 32'hFFFF_0000) | (hval & 32'hFFFF));
    endtask

    // One map for the current geometry. Unless whole is set, some maps are
    // cut short (the next map start restarts mid-map) and some get stray
    // cells after the end that the block must drop.
    task automatic queue_map(input bit whole, input bit counted);
        int unsigned wid;
        int unsigned hgt;
        int unsigned n;
        int unsigned extra;
        wid = (width_reg < 5) ? 5 :
              (width_reg > fcc_pkg::MAX_WIDTH) ? fcc_pkg::MAX_WIDTH : width_reg;
        hgt = (height_reg < 5) ? 5 : height_reg;
        n = wid * hgt;
        extra = 0;
        if (!whole) begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(1, n - 1);
                1: extra = $urandom_range(1, 6);
                default: ;
            endcase
        end
        for (int i = 0; i < n; i++) push_cell(pick_cell_value(), i == 0);
        for (int i = 0; i < extra; i++) push_cell(pick_cell_value(), 1'b0);
        if (counted) random_cells += n;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned wreg;
        int unsigned hreg;
        int unsigned roll;

        width_reg  = 12'd384;
        height_reg = 16'd384;
        row_idx    = 0;
        col_idx    = 0;
        foreach (hist_rows[k, c]) hist_rows[k][c] = fcc_pkg::CODE_NEUTRAL;
        foreach (nbhd[r, c]) nbhd[r][c] = fcc_pkg::CODE_NEUTRAL;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // profile 0: sender idles 12%, receiver 85%; 1: swapped; 2: no idling
        for (int profile = 0; profile < 3; profile++) begin
            send_idle_pct = (profile == 0) ? 12 : (profile == 1) ? 85 : 0;
            recv_idle_pct = (profile == 0) ? 85 : (profile == 1) ? 12 : 0;
            random_cells  = 0;

            if (profile == 0) begin
                // hand-made map: obstacle, plain and frontier centres,
                // then cells past the end of the map
                set_geometry(7, 5);
                foreach (HAND_MAP[i]) push_cell(HAND_MAP[i], i == 0);
                push_cell(CELL_FREE_VAL, 1'b0);
                push_cell(CELL_UNKNOWN_VAL, 1'b0);
                push_cell(CELL_OCCUPIED_VAL, 1'b0);

                // width and height below the minimum saturate to 5
                set_geometry(3, 0);
                queue_map(1'b1, 1'b0);

                // geometry shrunk mid-map: stop at row 6 col 10 of a 12x10 map,
                // then width 8 (column wraps) and height 9; the rows already
                // streamed keep every line buffer entry below col 8 written
                set_geometry(12, 10);
                for (int i = 0; i < 6 * 12 + 10; i++) push_cell(pick_cell_value(), i == 0);
                wait_idle();
                apb_write(fcc_pkg::REG_GRID_WIDTH, 32'd8);
                apb_write(fcc_pkg::REG_GRID_HEIGHT, 32'd9);
                for (int i = 0; i < 1 + 2 * 8 + 4; i++) push_cell(pick_cell_value(), 1'b0);
            end

            if (profile == 2) begin
                // widest setting, saturated: only the top row, no result due
                set_geometry(12'hFFF, 5);
                for (int i = 0; i < 60; i++) push_cell(pick_cell_value(), i == 0);
                // tallest setting, only the top of it
                set_geometry(5, 16'hFFFF);
                for (int i = 0; i < 40 * 5; i++) push_cell(pick_cell_value(), i == 0);
            end

            // random geometries, one to three maps back to back per setting
            while (random_cells < CELLS_PER_PROFILE) begin
                roll = $urandom_range(0, 15);
                wreg = (roll < 2) ? $urandom_range(0, 4) :
                       (roll < 14) ? $urandom_range(5, 24) : $urandom_range(25, 80);
                hreg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
                set_geometry(wreg, hreg);
                repeat ($urandom_range(1, 3)) queue_map(1'b0, 1'b1);
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("PASS frontier_cell_classifier");
        end else begin
            $display("FAIL frontier_cell_classifier");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #(TIMEOUT_NS * 1ns);
        $display("FAIL frontier_cell_classifier");
        $finish;
    end

endmodule

// File: filelist.f
hdl/fcc_pkg.sv
hdl/fcc_linebuf.sv
hdl/frontier_cell_classifier.sv
dv/frontier_cell_classifier_tb.sv
